// ===== sv/dfst_pkg.sv =====
`default_nettype none

package dfst_pkg;

  localparam int unsigned VertexCount = 8;
  localparam int unsigned VertexW     = 3;
  localparam int unsigned TimeW       = 5;
  localparam int unsigned DepthW      = 4;

  localparam logic [0:0] FuncLoad = 1'b0;
  localparam logic [0:0] FuncRun  = 1'b1;

  localparam logic [VertexCount-1:0] AllVertices = {VertexCount{1'b1}};

  typedef struct packed {
    logic [0:0]         func;
    logic [VertexW-1:0] vertex_index;
    logic [7:0]         neighbor_mask;
  } req_t;

  typedef struct packed {
    logic [VertexW-1:0] vertex;
    logic [TimeW-1:0]   discover_time;
    logic [TimeW-1:0]   finish_time;
    logic               has_parent;
    logic [VertexW-1:0] parent_vertex;
    logic               last_of_run;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/dfst_if.sv =====
`default_nettype none

interface dfst_req_if;
  logic          valid;
  logic          ready;
  dfst_pkg::req_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface dfst_res_if;
  logic          valid;
  logic          ready;
  dfst_pkg::res_t res;

  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

`default_nettype wire

// ===== sv/depth_first_search_timestamps.sv =====
// Depth-first search with discovery and finish time stamps over an 8-vertex
// directed graph.
// req_i (valid/ready) carries two kinds of request. A load request (func = 0)
// writes one vertex's outgoing-edge row and gives no result.
// A run request (func = 1) clears the visited marks and the clock, then
// walks from each unvisited root in ascending order, neighbors ascending.
// res_o (valid/ready) gives one result per vertex in finish order: vertex,
// discovery and finish times, parent and a last flag on the final one.
// While a run is under way req_i.ready stays low. The run takes one
// sequencer step per root scan slot, per discovery and per finish, plus
// one to end the scan, each step sharing one row lookup of the vertex on
// top of the stack. A new run is accepted only after the last one ends;
// loads are accepted every cycle while the sequencer is idle.
// Results pass through a single output register; a stalled receiver holds
// the sequencer at the next finish until that register frees up.
// Reset clears the edge rows (no edges), the sequencer and the output valid.
`default_nettype none

module depth_first_search_timestamps (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dfst_req_if.sink  req_i,
  dfst_res_if.source res_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRoot = 2'd1;
  localparam logic [1:0] StStep = 2'd2;

  localparam int unsigned N  = dfst_pkg::VertexCount;
  localparam int unsigned VW = dfst_pkg::VertexW;
  localparam int unsigned TW = dfst_pkg::TimeW;
  localparam int unsigned DW = dfst_pkg::DepthW;

  logic [1:0]    state_q, state_d;
  logic [N-1:0]  visited_q, visited_d;
  logic [TW-1:0] clock_q, clock_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [DW-1:0] root_q, root_d;
  logic [VW-1:0] fin_cnt_q, fin_cnt_d;
  logic          out_valid_q, out_valid_d;
  dfst_pkg::res_t out_q;

  logic [N-1:0]  adj_q [N];
  logic [VW-1:0] stack_q [N];
  logic [TW-1:0] disc_q [N];
  logic [VW:0]   parent_q [N];

  logic [VW-1:0] top;
  logic [N-1:0]  fresh;
  logic [VW-1:0] low_idx;
  logic          out_free;
  logic          load_en;
  logic          do_push;
  logic [VW-1:0] push_vtx;
  logic [VW:0]   push_par;
  logic          do_pop;

  assign top      = stack_q[depth_q[VW-1:0] - VW'(1)];
  assign fresh    = adj_q[top] & ~visited_q;
  assign out_free = !out_valid_q || res_o.ready;
  assign load_en  = (state_q == StIdle) && req_i.valid && (req_i.req.func == dfst_pkg::FuncLoad)
                    && ({1'b0, req_i.req.vertex_index} < (VW+1)'(N));

  always_comb begin
    low_idx = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (fresh[k]) begin
        low_idx = VW'(k);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    visited_d   = visited_q;
    clock_d     = clock_q;
    depth_d     = depth_q;
    root_d      = root_q;
    fin_cnt_d   = fin_cnt_q;
    out_valid_d = out_valid_q && !res_o.ready;
    do_push     = 1'b0;
    push_vtx    = '0;
    push_par    = '0;
    do_pop      = 1'b0;
    case (state_q)
      StIdle: begin
        if (req_i.valid && (req_i.req.func == dfst_pkg::FuncRun)) begin
          visited_d = '0;
          clock_d   = '0;
          depth_d   = '0;
          root_d    = '0;
          fin_cnt_d = '0;
          state_d   = StRoot;
        end
      end
      StRoot: begin
        if (root_q == DW'(N)) begin
          state_d = StIdle;
        end else if (visited_q[root_q[VW-1:0]]) begin
          root_d = root_q + DW'(1);
        end else begin
          do_push  = 1'b1;
          push_vtx = root_q[VW-1:0];
          state_d  = StStep;
        end
      end
      StStep: begin
        if (fresh != '0) begin
          do_push  = 1'b1;
          push_vtx = low_idx;
          push_par = {1'b1, top};
        end else if (out_free) begin
          do_pop      = 1'b1;
          depth_d     = depth_q - DW'(1);
          clock_d     = clock_q + TW'(1);
          fin_cnt_d   = fin_cnt_q + VW'(1);
          out_valid_d = 1'b1;
          if (depth_q == DW'(1)) begin
            state_d = StRoot;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (do_push) begin
      visited_d = visited_q | (N'(1) << push_vtx);
      clock_d   = clock_q + TW'(1);
      depth_d   = depth_q + DW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      visited_q   <= '0;
      clock_q     <= '0;
      depth_q     <= '0;
      root_q      <= '0;
      fin_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        adj_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      visited_q   <= visited_d;
      clock_q     <= clock_d;
      depth_q     <= depth_d;
      root_q      <= root_d;
      fin_cnt_q   <= fin_cnt_d;
      out_valid_q <= out_valid_d;
      if (load_en) begin
        adj_q[req_i.req.vertex_index] <= req_i.req.neighbor_mask[N-1:0] & dfst_pkg::AllVertices;
      end
    end
  end

  // Stack, time stamps and parents are written before they are read in a run.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      stack_q[depth_q[VW-1:0]] <= push_vtx;
      disc_q[push_vtx]         <= clock_q + TW'(1);
      parent_q[push_vtx]       <= push_par;
    end
    if (do_pop) begin
      out_q.vertex        <= top;
      out_q.discover_time <= disc_q[top];
      out_q.finish_time   <= clock_q + TW'(1);
      out_q.has_parent    <= parent_q[top][VW];
      out_q.parent_vertex <= parent_q[top][VW-1:0];
      out_q.last_of_run   <= (fin_cnt_q == VW'(N - 1));
    end
  end

  assign req_i.ready = (state_q == StIdle);
  assign res_o.valid = out_valid_q;
  assign res_o.res   = out_q;

endmodule

`default_nettype wire
